// File: rtl/bts_pkg.sv
// Package of the bilinear texture sampler: sizes, command codes and widths.
// Used by the input channel interface and the top level.
`default_nettype none
package bts_pkg;

  localparam int MAX_DIM    = 64;
  localparam int COORD_W    = $clog2(MAX_DIM);          // texel column/row bits
  localparam int HALF_W     = COORD_W - 1;              // bits of a bank row/column
  localparam int BANK_AW    = 2 * HALF_W;               // bank address bits
  localparam int BANK_DEPTH = (MAX_DIM / 2) * (MAX_DIM / 2);
  localparam int DIM_W      = 7;                        // register width
  localparam int FRAC_W     = 16;
  localparam int UV_W       = FRAC_W + 1;               // Q1.16
  localparam int WGT_W      = 2 * FRAC_W + 1;           // Q1.32 weight
  localparam int PROD_W     = WGT_W + 8;                // channel times weight
  localparam int CFG_IDX_W  = 1;

  localparam logic [UV_W-1:0] UV_ONE = UV_W'(1 << FRAC_W);

  typedef enum logic [0:0] {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [31:0] texel_t;

endpackage
`default_nettype wire

// File: rtl/bts_in_if.sv
// Input channel of the texture sampler: handshake and one command item.
// Depends on bts_pkg.
`default_nettype none
interface bts_in_if
  import bts_pkg::*;
;
  logic                valid;
  logic                ready;
  cmd_t                command;
  logic [COORD_W-1:0]  texel_x;
  logic [COORD_W-1:0]  texel_y;
  texel_t              texel_data;
  logic [UV_W-1:0]     coord_u;
  logic [UV_W-1:0]     coord_v;

  modport source (output valid, command, texel_x, texel_y, texel_data, coord_u, coord_v,
                  input ready);
  modport sink   (input valid, command, texel_x, texel_y, texel_data, coord_u, coord_v,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/bts_out_if.sv
// Output channel of the texture sampler: handshake and one filtered RGBA item.
// No dependencies.
`default_nettype none
interface bts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface
`default_nettype wire

// File: rtl/bts_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`default_nettype none
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/bilinear_texture_sampler.sv
// Bilinear RGBA8 texture sampler top level.
// Depends on bts_pkg, bts_in_if, bts_out_if and bts_ram.
`default_nettype none
// Takes one item per clock unless stalled: a texel write (no result) or a
// bilinear sample (one RGBA8 result). A sample result passes through five
// register stages: coordinate scaling, banked texel read, weight multiply,
// channel multiply, and the sum/round into the output register. The texel
// store is four 1024-word RAMs banked by column and row parity, so the
// four corners of a sample always hit four different banks in the same cycle.
// The whole pipeline advances together; it stalls only while a finished
// result waits in the output register. Reading a texel that was never
// written gives undefined data.
module bilinear_texture_sampler
  import bts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  bts_in_if.sink                    in,
  bts_out_if.source                 out
);

  // Configuration registers
  logic [DIM_W-1:0] tex_width, tex_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= DIM_W'(MAX_DIM);
      tex_height <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEX_WIDTH:  tex_width  <= cfg_data;
        REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: move when output is free or being taken
  logic en;
  assign en       = !out.valid || out.ready;
  assign in.ready = en;

  // Stage 0: clamp and scale
  function automatic logic [COORD_W-1:0] dim_m1(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] c;
    c = d;
    if (d == '0) c = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) c = DIM_W'(MAX_DIM);
    return COORD_W'(c - DIM_W'(1));
  endfunction

  logic [UV_W-1:0]            u_c, v_c;
  logic [COORD_W+UV_W-1:0]    pu, pv;

  always_comb begin
    u_c = (in.coord_u > UV_ONE) ? UV_ONE : in.coord_u;
    v_c = (in.coord_v > UV_ONE) ? UV_ONE : in.coord_v;
    pu  = (COORD_W+UV_W)'(dim_m1(tex_width))  * (COORD_W+UV_W)'(u_c);
    pv  = (COORD_W+UV_W)'(dim_m1(tex_height)) * (COORD_W+UV_W)'(v_c);
  end

  // Stage 1 registers
  logic               v1;
  cmd_t               cmd1;
  logic [COORD_W-1:0] wx1, wy1, lx1, ly1;
  texel_t             wd1;
  logic [FRAC_W-1:0]  fu1, fv1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= in.command;
      wx1  <= in.texel_x;
      wy1  <= in.texel_y;
      wd1  <= in.texel_data;
      lx1  <= pu[FRAC_W +: COORD_W];
      ly1  <= pv[FRAC_W +: COORD_W];
      fu1  <= pu[FRAC_W-1:0];
      fv1  <= pv[FRAC_W-1:0];
    end
  end

  // Bank addressing: even and odd column/row index around the low corner
  logic [HALF_W-1:0] xi [2];
  logic [HALF_W-1:0] yi [2];
  texel_t            bank_q [4];

  always_comb begin
    xi[1] = lx1[COORD_W-1:1];
    xi[0] = lx1[COORD_W-1:1] + HALF_W'(lx1[0]);
    yi[1] = ly1[COORD_W-1:1];
    yi[0] = ly1[COORD_W-1:1] + HALF_W'(ly1[0]);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic bwe;
    assign bwe = en && v1 && (cmd1 == CMD_WRITE) &&
                 (wx1[0] == 1'(b % 2)) && (wy1[0] == 1'(b / 2));
    bts_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_ram (
      .clk   (clk),
      .we    (bwe),
      .waddr ({wy1[COORD_W-1:1], wx1[COORD_W-1:1]}),
      .wdata (wd1),
      .re    (en),
      .raddr ({yi[b/2], xi[b%2]}),
      .rdata (bank_q[b])
    );
  end

  // Stage 2 registers (texels come from the RAMs)
  logic              v2, lx0_2, ly0_2;
  logic [FRAC_W-1:0] fu2, fv2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1 && (cmd1 == CMD_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx0_2 <= lx1[0];
      ly0_2 <= ly1[0];
      fu2   <= fu1;
      fv2   <= fv1;
    end
  end

  // Corner select; a zero-weight corner is forced to zero
  texel_t            t2 [4];
  logic [FRAC_W:0]   gu2, gv2;
  logic [WGT_W-1:0]  w2 [4];

  always_comb begin
    t2[0] = bank_q[{ly0_2,  lx0_2}];
    t2[1] = (fu2 != '0) ? bank_q[{ly0_2, ~lx0_2}] : '0;
    t2[2] = (fv2 != '0) ? bank_q[{~ly0_2, lx0_2}] : '0;
    t2[3] = (fu2 != '0 && fv2 != '0) ? bank_q[{~ly0_2, ~lx0_2}] : '0;
    gu2   = UV_ONE - UV_W'(fu2);
    gv2   = UV_ONE - UV_W'(fv2);
    w2[0] = WGT_W'(gu2) * WGT_W'(gv2);
    w2[1] = WGT_W'(fu2) * WGT_W'(gv2);
    w2[2] = WGT_W'(gu2) * WGT_W'(fv2);
    w2[3] = WGT_W'(fu2) * WGT_W'(fv2);
  end

  // Stage 3 registers: texels and weights
  logic             v3;
  texel_t           t3 [4];
  logic [WGT_W-1:0] w3 [4];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3 <= t2;
      w3 <= w2;
    end
  end

  // Stage 4: channel times weight
  logic              v4;
  logic [PROD_W-1:0] pr4 [4][4];  // [channel][corner]

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          pr4[c][k] <= PROD_W'(t3[k][8*c +: 8]) * PROD_W'(w3[k]);
        end
      end
    end
  end

  // Sum, round to nearest, output register
  logic [PROD_W-1:0] acc [4];
  logic [7:0]        ch  [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = pr4[c][0] + pr4[c][1] + pr4[c][2] + pr4[c][3]
             + PROD_W'(64'h8000_0000);
      ch[c]  = acc[c][2*FRAC_W +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (en) out.valid <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.out_red   <= ch[0];
      out.out_green <= ch[1];
      out.out_blue  <= ch[2];
      out.out_alpha <= ch[3];
    end
  end

endmodule
`default_nettype wire
